FILE: sv/vaxr_pkg.sv
// Shared types, constants and the arctangent table of the axis rotation block.
`default_nettype none

package vaxr_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int FRAC_BITS     = 16;

    localparam int TAB_LEN = 30;
    localparam int TAB_W   = $clog2(TAB_LEN);
    localparam int COMP_W  = 32;
    localparam int ANG_W   = 26;
    localparam int CW      = 34;
    localparam int COEF_W  = 32;
    localparam int PROD_W  = COMP_W + COEF_W;
    localparam int DEG_W   = 27;

    localparam int PREP_LAT = 7;
    localparam int OUT_LAT  = 3;
    localparam int LAT      = PREP_LAT + CORDIC_STAGES + OUT_LAT;

    localparam logic signed [CW-1:0]     CORDIC_GAIN = CW'(652032874);
    localparam logic [DEG_W-1:0]         DEG_TO_RAD  = DEG_W'(74961321);
    localparam logic signed [COEF_W-1:0] ONE_Q30     = COEF_W'(1 << 30);

    typedef enum logic [1:0] {
        KIND_ROLL  = 2'd0,
        KIND_YAW   = 2'd1,
        KIND_PITCH = 2'd2,
        KIND_PASS  = 2'd3
    } t_kind;

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef logic signed [CW-1:0]     t_cw;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic [TAB_W-1:0]         t_stage;

    typedef struct packed {
        t_kind kind;
        t_comp x;
        t_comp y;
        t_comp z;
        logic  neg_sin;
        logic  neg_cos;
    } t_side;

    // atan(2^-i) in radians, Q2.30
    function automatic t_cw atan_q30(input t_stage idx);
        t_cw v;
        case (idx)
            5'd0:    v = CW'(32'h3243F6A8);
            5'd1:    v = CW'(32'h1DAC6705);
            5'd2:    v = CW'(32'h0FADBAFC);
            5'd3:    v = CW'(32'h07F56EA6);
            5'd4:    v = CW'(32'h03FEAB76);
            5'd5:    v = CW'(32'h01FFD55B);
            5'd6:    v = CW'(32'h00FFFAAA);
            5'd7:    v = CW'(32'h007FFF55);
            5'd8:    v = CW'(32'h003FFFEA);
            5'd9:    v = CW'(32'h001FFFFD);
            5'd10:   v = CW'(32'h000FFFFF);
            5'd11:   v = CW'(32'h0007FFFF);
            5'd12:   v = CW'(32'h0003FFFF);
            5'd13:   v = CW'(32'h0001FFFF);
            5'd14:   v = CW'(32'h0000FFFF);
            5'd15:   v = CW'(32'h00007FFF);
            5'd16:   v = CW'(32'h00003FFF);
            5'd17:   v = CW'(32'h00001FFF);
            5'd18:   v = CW'(32'h00000FFF);
            5'd19:   v = CW'(32'h000007FF);
            5'd20:   v = CW'(32'h000003FF);
            5'd21:   v = CW'(32'h000001FF);
            5'd22:   v = CW'(32'h000000FF);
            5'd23:   v = CW'(32'h0000007F);
            5'd24:   v = CW'(32'h0000003F);
            5'd25:   v = CW'(32'h0000001F);
            5'd26:   v = CW'(32'h0000000F);
            5'd27:   v = CW'(32'h00000008);
            5'd28:   v = CW'(32'h00000004);
            5'd29:   v = CW'(32'h00000002);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: sv/vaxr_angle_prep.sv
// Angle reduction to the first quadrant and conversion to Q2.30 radians.
`default_nettype none

module vaxr_angle_prep import vaxr_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire t_side                   i_side,
    input  wire logic signed [ANG_W-1:0] i_angle,
    output logic                         o_valid,
    output t_cw                          o_x,
    output t_cw                          o_y,
    output t_cw                          o_z,
    output t_side                        o_side
);

    localparam logic [63:0] TURN64 = 64'd360 << FRAC_BITS;
    localparam int TURN_W = FRAC_BITS + 9;
    localparam int QUAR_W = FRAC_BITS + 7;
    localparam logic [TURN_W-1:0] TURN    = TURN_W'(TURN64);
    localparam logic [TURN_W-1:0] HALF    = TURN_W'(TURN64 >> 1);
    localparam logic [TURN_W-1:0] QUARTER = TURN_W'(TURN64 >> 2);
    // reciprocal of one turn, scaled by 2^ANG_W; the quotient estimate is low by at most one
    localparam logic [63:0] RECIP64 = (64'd1 << ANG_W) / TURN64;
    localparam int RECIP_W = $clog2(RECIP64 + 64'd1) + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP64);
    localparam int MAG_W = ANG_W;
    localparam int MP_W  = MAG_W + RECIP_W;
    localparam int W2    = ((MAG_W > RECIP_W + TURN_W) ? MAG_W : RECIP_W + TURN_W) + 1;
    localparam int REM_W = TURN_W + 1;
    localparam int RAD_W = QUAR_W + DEG_W;
    localparam int RND_W = RAD_W + 1;
    localparam int Z_W   = RND_W - (FRAC_BITS + 2);

    logic [PREP_LAT-1:0] r_vld;
    t_side               r_side [PREP_LAT];

    logic [MAG_W-1:0]   r_amag1;
    logic [RECIP_W-1:0] r_q1;
    logic [REM_W-1:0]   r_rem2;
    logic [TURN_W-1:0]  r_u3;
    logic [TURN_W-1:0]  r_mag4;
    logic [QUAR_W-1:0]  r_fold5;
    logic [RAD_W-1:0]   r_rad6;
    logic [Z_W-1:0]     r_z7;

    logic signed [ANG_W:0] n_aext;
    logic signed [ANG_W:0] n_aabs;
    logic [MP_W-1:0]       n_mp;
    logic [W2-1:0]         n_diff;
    logic [TURN_W-1:0]     n_u;
    logic [TURN_W-1:0]     n_mag;
    logic                  n_neg_sin;
    logic [QUAR_W-1:0]     n_fold;
    logic                  n_neg_cos;
    logic [RND_W-1:0]      n_rnd;
    t_side                 n_side0;
    t_side                 n_side3;
    t_side                 n_side4;

    always_comb begin
        n_aext = {i_angle[ANG_W-1], i_angle};
        n_aabs = i_angle[ANG_W-1] ? -n_aext : n_aext;
        n_mp   = MP_W'(n_aabs[MAG_W-1:0]) * MP_W'(RECIP);

        n_side0         = i_side;
        n_side0.neg_sin = i_angle[ANG_W-1];
        n_side0.neg_cos = 1'b0;

        n_diff = W2'(r_amag1) - W2'(W2'(r_q1) * W2'(TURN));

        n_u = (r_rem2 >= REM_W'(TURN)) ? TURN_W'(r_rem2 - REM_W'(TURN))
                                       : r_rem2[TURN_W-1:0];

        // wrap into (-half, half]; the stored sign so far is the sign of the angle
        if (!r_side[2].neg_sin && (r_u3 > HALF)) begin
            n_mag     = TURN - r_u3;
            n_neg_sin = 1'b1;
        end else if (r_side[2].neg_sin && (r_u3 >= HALF)) begin
            n_mag     = TURN - r_u3;
            n_neg_sin = 1'b0;
        end else begin
            n_mag     = r_u3;
            n_neg_sin = r_side[2].neg_sin && (r_u3 != '0);
        end

        n_side3         = r_side[2];
        n_side3.neg_sin = n_neg_sin;

        if (r_mag4 > QUARTER) begin
            n_fold    = QUAR_W'(HALF - r_mag4);
            n_neg_cos = 1'b1;
        end else begin
            n_fold    = QUAR_W'(r_mag4);
            n_neg_cos = 1'b0;
        end

        n_side4         = r_side[3];
        n_side4.neg_cos = n_neg_cos;

        n_rnd = RND_W'(r_rad6) + (RND_W'(1) << (FRAC_BITS + 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PREP_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= n_side0;
        r_amag1   <= n_aabs[MAG_W-1:0];
        r_q1      <= n_mp[MP_W-1:ANG_W];

        r_side[1] <= r_side[0];
        r_rem2    <= n_diff[REM_W-1:0];

        r_side[2] <= r_side[1];
        r_u3      <= n_u;

        r_side[3] <= n_side3;
        r_mag4    <= n_mag;

        r_side[4] <= n_side4;
        r_fold5   <= n_fold;

        r_side[5] <= r_side[4];
        r_rad6    <= RAD_W'(r_fold5) * RAD_W'(DEG_TO_RAD);

        r_side[6] <= r_side[5];
        r_z7      <= n_rnd[RND_W-1:FRAC_BITS+2];
    end

    assign o_valid = r_vld[PREP_LAT-1];
    assign o_side  = r_side[PREP_LAT-1];
    assign o_x     = CORDIC_GAIN;
    assign o_y     = '0;
    assign o_z     = $signed(CW'(r_z7));

endmodule

`default_nettype wire

FILE: sv/vaxr_cordic_cell.sv
// One rotation-mode CORDIC iteration with its output register.
`default_nettype none

module vaxr_cordic_cell import vaxr_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_stage i_stage,
    input  wire logic   i_valid,
    input  wire t_cw    i_x,
    input  wire t_cw    i_y,
    input  wire t_cw    i_z,
    input  wire t_side  i_side,
    output logic        o_valid,
    output t_cw         o_x,
    output t_cw         o_y,
    output t_cw         o_z,
    output t_side       o_side
);

    logic  r_valid;
    t_cw   r_x;
    t_cw   r_y;
    t_cw   r_z;
    t_side r_side;

    t_cw n_dx;
    t_cw n_dy;
    t_cw n_at;
    t_cw n_x;
    t_cw n_y;
    t_cw n_z;

    always_comb begin
        n_dx = i_y >>> i_stage;
        n_dy = i_x >>> i_stage;
        n_at = atan_q30(i_stage);
        // turn toward zero residual angle
        if (!i_z[CW-1]) begin
            n_x = i_x - n_dx;
            n_y = i_y + n_dy;
            n_z = i_z - n_at;
        end else begin
            n_x = i_x + n_dx;
            n_y = i_y - n_dy;
            n_z = i_z + n_at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

`default_nettype wire

FILE: sv/vaxr_rotate_out.sv
// Quadrant signs, per-axis products, rounding and saturation of the rotated vector.
`default_nettype none

module vaxr_rotate_out import vaxr_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_cw   i_cos,
    input  wire t_cw   i_sin,
    input  wire t_side i_side,
    output logic       o_strobe,
    output t_comp      o_x_out,
    output t_comp      o_y_out,
    output t_comp      o_z_out
);

    localparam int SUM_W  = PROD_W + 1;
    localparam int Q30_SH = 30;
    localparam int LX = 0;
    localparam int LY = 1;
    localparam int LZ = 2;

    typedef struct packed {
        t_comp own;
        t_coef own_k;
        t_comp oth;
        t_coef oth_k;
    } t_lane;

    function automatic t_comp round_sat(input logic signed [PROD_W-1:0] a,
                                        input logic signed [PROD_W-1:0] b);
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] q;
        t_comp                   v;
        s = SUM_W'(a) + SUM_W'(b) + (SUM_W'(1) <<< (Q30_SH - 1));
        q = s >>> Q30_SH;
        if (q > SUM_W'(t_comp'({1'b0, {(COMP_W-1){1'b1}}}))) begin
            v = {1'b0, {(COMP_W-1){1'b1}}};
        end else if (q < SUM_W'(t_comp'({1'b1, {(COMP_W-1){1'b0}}}))) begin
            v = {1'b1, {(COMP_W-1){1'b0}}};
        end else begin
            v = q[COMP_W-1:0];
        end
        return v;
    endfunction

    logic  r_vld_a;
    logic  r_vld_b;
    logic  r_strobe;
    t_lane r_lane [3];
    logic signed [PROD_W-1:0] r_p_own [3];
    logic signed [PROD_W-1:0] r_p_oth [3];
    t_comp r_x_out;
    t_comp r_y_out;
    t_comp r_z_out;

    t_cw   n_c;
    t_cw   n_s;
    t_cw   n_ns;
    t_coef n_ck;
    t_coef n_sk;
    t_coef n_nsk;
    t_lane n_lane [3];

    always_comb begin
        n_c   = i_side.neg_cos ? -i_cos : i_cos;
        n_s   = i_side.neg_sin ? -i_sin : i_sin;
        n_ns  = -n_s;
        n_ck  = n_c[COEF_W-1:0];
        n_sk  = n_s[COEF_W-1:0];
        n_nsk = n_ns[COEF_W-1:0];

        // untouched lanes multiply by one and add nothing
        n_lane[LX] = '{own: i_side.x, own_k: ONE_Q30, oth: '0, oth_k: '0};
        n_lane[LY] = '{own: i_side.y, own_k: ONE_Q30, oth: '0, oth_k: '0};
        n_lane[LZ] = '{own: i_side.z, own_k: ONE_Q30, oth: '0, oth_k: '0};

        unique case (i_side.kind)
            KIND_ROLL: begin
                n_lane[LX] = '{own: i_side.x, own_k: n_ck, oth: i_side.y, oth_k: n_nsk};
                n_lane[LY] = '{own: i_side.y, own_k: n_ck, oth: i_side.x, oth_k: n_sk};
            end
            KIND_YAW: begin
                n_lane[LX] = '{own: i_side.x, own_k: n_ck, oth: i_side.z, oth_k: n_sk};
                n_lane[LZ] = '{own: i_side.z, own_k: n_ck, oth: i_side.x, oth_k: n_nsk};
            end
            KIND_PITCH: begin
                n_lane[LY] = '{own: i_side.y, own_k: n_ck, oth: i_side.z, oth_k: n_nsk};
                n_lane[LZ] = '{own: i_side.z, own_k: n_ck, oth: i_side.y, oth_k: n_sk};
            end
            KIND_PASS: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a  <= 1'b0;
            r_vld_b  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_vld_a  <= i_valid;
            r_vld_b  <= r_vld_a;
            r_strobe <= r_vld_b;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_lane[i]  <= n_lane[i];
            r_p_own[i] <= $signed(r_lane[i].own) * $signed(r_lane[i].own_k);
            r_p_oth[i] <= $signed(r_lane[i].oth) * $signed(r_lane[i].oth_k);
        end
        r_x_out <= round_sat(r_p_own[LX], r_p_oth[LX]);
        r_y_out <= round_sat(r_p_own[LY], r_p_oth[LY]);
        r_z_out <= round_sat(r_p_own[LZ], r_p_oth[LZ]);
    end

    assign o_strobe = r_strobe;
    assign o_x_out  = r_x_out;
    assign o_y_out  = r_y_out;
    assign o_z_out  = r_z_out;

endmodule

`default_nettype wire

FILE: sv/vector_axis_rotate_3d_top.sv
// Top level of the three-dimensional elementary axis rotation block.
//
// Rotates a Q15.16 vector counterclockwise about z (kind 0), y (kind 1) or x (kind 2) by an
// angle in Q9.16 degrees; kind 3 passes the vector through. One vector is taken every cycle:
// busy is low except during reset and the cycle after it. Each result appears on the output
// ports for one cycle with o_strobe high, after its start beat has passed angle reduction and
// radian conversion, the 16-cell CORDIC chain, and sign fixup, multiply and round/saturate.
// There is no output back-pressure, so the receiver must take every strobed beat.
`default_nettype none

module vector_axis_rotate_3d_top import vaxr_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [1:0]               i_kind,
    input  wire logic signed [COMP_W-1:0] i_x_in,
    input  wire logic signed [COMP_W-1:0] i_y_in,
    input  wire logic signed [COMP_W-1:0] i_z_in,
    input  wire logic signed [ANG_W-1:0]  i_angle_deg,
    output logic                          o_strobe,
    output logic signed [COMP_W-1:0]      o_x_out,
    output logic signed [COMP_W-1:0]      o_y_out,
    output logic signed [COMP_W-1:0]      o_z_out
);

    logic  r_rdy;
    logic  accept;
    t_side side_in;

    logic  c_vld  [CORDIC_STAGES+1];
    t_cw   c_x    [CORDIC_STAGES+1];
    t_cw   c_y    [CORDIC_STAGES+1];
    t_cw   c_z    [CORDIC_STAGES+1];
    t_side c_side [CORDIC_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy <= 1'b0;
        end else begin
            r_rdy <= 1'b1;
        end
    end

    assign busy   = !(r_rdy && i_rst_n);
    assign accept = start && !busy;

    always_comb begin
        side_in.kind    = t_kind'(i_kind);
        side_in.x       = i_x_in;
        side_in.y       = i_y_in;
        side_in.z       = i_z_in;
        side_in.neg_sin = 1'b0;
        side_in.neg_cos = 1'b0;
    end

    vaxr_angle_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_side  (side_in),
        .i_angle (i_angle_deg),
        .o_valid (c_vld[0]),
        .o_x     (c_x[0]),
        .o_y     (c_y[0]),
        .o_z     (c_z[0]),
        .o_side  (c_side[0])
    );

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
        vaxr_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (t_stage'(k)),
            .i_valid (c_vld[k]),
            .i_x     (c_x[k]),
            .i_y     (c_y[k]),
            .i_z     (c_z[k]),
            .i_side  (c_side[k]),
            .o_valid (c_vld[k+1]),
            .o_x     (c_x[k+1]),
            .o_y     (c_y[k+1]),
            .o_z     (c_z[k+1]),
            .o_side  (c_side[k+1])
        );
    end

    vaxr_rotate_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (c_vld[CORDIC_STAGES]),
        .i_cos    (c_x[CORDIC_STAGES]),
        .i_sin    (c_y[CORDIC_STAGES]),
        .i_side   (c_side[CORDIC_STAGES]),
        .o_strobe (o_strobe),
        .o_x_out  (o_x_out),
        .o_y_out  (o_y_out),
        .o_z_out  (o_z_out)
    );

    // every strobed beat comes from a matching accepted start beat
    a_no_stray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, LAT))
        else $error("result strobe without a matching start beat");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_strobe)
        else $error("start beat produced no result");

    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && ($past(i_kind, LAT) == KIND_PASS)) |->
            ((o_x_out == $past(i_x_in, LAT)) && (o_y_out == $past(i_y_in, LAT)) &&
             (o_z_out == $past(i_z_in, LAT))))
        else $error("pass-through vector altered");

    a_roll_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && ($past(i_kind, LAT) == KIND_ROLL)) |-> (o_z_out == $past(i_z_in, LAT)))
        else $error("z changed by a rotation about z");

endmodule

`default_nettype wire
